/* rtl/core/cdq_pkg.sv */
// shared types and codes for the circular deque
package cdq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int WORD_W    = 32;

    // operation codes carried by func
    localparam logic [2:0] FUNC_QUERY     = 3'd0;
    localparam logic [2:0] FUNC_INS_FRONT = 3'd1;
    localparam logic [2:0] FUNC_INS_REAR  = 3'd2;
    localparam logic [2:0] FUNC_REM_FRONT = 3'd3;
    localparam logic [2:0] FUNC_REM_REAR  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } cdq_state_t;

    typedef struct packed {
        logic exec;   // apply the accepted operation to the indexes and store
        logic rd_en;  // read front and rear entries into the read registers
    } cdq_cmd_t;

endpackage

/* rtl/core/cdq_ctrl.sv */
// sequencing state machine for the circular deque
module cdq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output cdq_pkg::cdq_cmd_t cmd
);
    import cdq_pkg::*;

    cdq_state_t state_reg;
    cdq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.exec = in_valid;
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/cdq_datapath.sv */
// index registers, word store and result registers of the circular deque
module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdq_pkg::cdq_cmd_t           cmd,
    input  logic [2:0]                  func,
    input  logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic signed [cdq_pkg::WORD_W-1:0] front_value,
    output logic signed [cdq_pkg::WORD_W-1:0] rear_value,
    output logic                        empty_res,
    output logic                        full_res,
    output logic [1:0]                  status
);
    import cdq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [WORD_W-1:0] store_mem [DEPTH];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [1:0]       status_reg, status_next;
    logic [WORD_W-1:0] front_rd_reg;
    logic [WORD_W-1:0] rear_rd_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic             full_now;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign full_now = !empty_reg && (tail_inc == head_reg);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = '0;
        if (func == FUNC_INS_FRONT || func == FUNC_INS_REAR)
        begin
            priority if (full_now)
            begin
                status_next = ST_FULL;
            end
            else if (empty_reg)
            begin
                // first word always lands in entry zero
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                wr_en      = 1'b1;
                wr_addr    = '0;
            end
            else if (func == FUNC_INS_FRONT)
            begin
                head_next = head_dec;
                wr_en     = 1'b1;
                wr_addr   = head_dec;
            end
            else
            begin
                tail_next = tail_inc;
                wr_en     = 1'b1;
                wr_addr   = tail_inc;
            end
        end
        else if (func == FUNC_REM_FRONT || func == FUNC_REM_REAR)
        begin
            priority if (empty_reg)
            begin
                status_next = ST_EMPTY;
            end
            else if (head_reg == tail_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
            end
            else if (func == FUNC_REM_FRONT)
            begin
                head_next = head_inc;
            end
            else
            begin
                tail_next = tail_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            empty_reg  <= 1'b1;
            status_reg <= ST_DONE;
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            status_reg <= status_next;
        end
    end

    // store write port
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            store_mem[wr_addr] <= value;
        end
    end

    // two registered read ports at front and rear
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            front_rd_reg <= store_mem[head_reg];
            rear_rd_reg  <= store_mem[tail_reg];
        end
    end

    assign front_value = empty_reg ? '1 : front_rd_reg;
    assign rear_value  = empty_reg ? '1 : rear_rd_reg;
    assign empty_res   = empty_reg;
    assign full_res    = full_now;
    assign status      = status_reg;

endmodule

/* rtl/core/circular_deque.sv */
// Circular deque of signed 32-bit words over a DEPTH-entry store. Each accepted beat carries one
// operation (query, insert front/rear, remove front/rear) and yields exactly one result beat with
// the front and rear words after the operation (-1 when empty), empty and full flags, and a
// status (done, insert refused when full, removal refused when empty). The result beat is offered
// in the output state, which follows the accept and read states, and no new input beat is taken
// until the result beat leaves, which it does only while out_stall is low: the store is written in
// the accept cycle, then read at front and rear through its two registered read ports before the
// result is shown. No clearing pass is needed after reset; unwritten entries never reach the
// outputs, which show -1 while the deque is empty.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  func,
    input  logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [cdq_pkg::WORD_W-1:0] front_value,
    output logic signed [cdq_pkg::WORD_W-1:0] rear_value,
    output logic                        empty_res,
    output logic                        full_res,
    output logic [1:0]                  status
);
    import cdq_pkg::*;

    cdq_cmd_t cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .value       (value),
        .front_value (front_value),
        .rear_value  (rear_value),
        .empty_res   (empty_res),
        .full_res    (full_res),
        .status      (status)
    );

endmodule
